[hw/rtl/rgbc_pkg.sv]
// ----------------------------------------------------------------------------
// rgbc_pkg
// Shared types and constants for the 3x3 RGB convolution block.
// ----------------------------------------------------------------------------
`default_nettype none

package rgbc_pkg;

  localparam int PIX_W          = 8;
  localparam int FRAME_W_BITS   = 12;
  localparam int FRAME_H_BITS   = 13;
  localparam int COEF_REG_BITS  = 48;
  localparam int COEF_SLOT_BITS = 16;
  localparam int CFG_IDX_BITS   = 3;
  localparam int WIN_TAPS       = 9;
  localparam int MIN_WIDTH      = 32;
  localparam int CLAMP_MAX      = 255;

  localparam logic FUNC_PIXEL = 1'b0;
  localparam logic FUNC_DRAIN = 1'b1;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_FRAME_WIDTH  = 3'd0,
    CFG_FRAME_HEIGHT = 3'd1,
    CFG_COEF_TOP     = 3'd2,
    CFG_COEF_MID     = 3'd3,
    CFG_COEF_BOTTOM  = 3'd4
  } cfg_idx_t;

  typedef struct packed {
    logic [PIX_W-1:0] red;
    logic [PIX_W-1:0] green;
    logic [PIX_W-1:0] blue;
  } rgb_t;

  // Per-item decisions made at the input, carried down the pipeline.
  typedef struct packed {
    logic emit;      // this item releases a result
    logic left_ok;   // left window column lies inside the frame
    logic top_ok;    // top window row lies inside the frame
    logic right_ok;  // right window column is the incoming column
    logic last;      // result is the frame's final pixel
  } item_flags_t;

endpackage

`default_nettype wire

[hw/rtl/rgbc_ctrl.sv]
// ----------------------------------------------------------------------------
// rgbc_ctrl
// Configuration registers, frame counters and per-item window decisions.
// ----------------------------------------------------------------------------
`default_nettype none

module rgbc_ctrl
  import rgbc_pkg::*;
#(
  parameter int MAX_WIDTH  = 2048,
  parameter int MAX_HEIGHT = 4096,
  parameter int COEF_BITS  = 16,
  localparam int CW = $clog2(MAX_WIDTH)
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [CFG_IDX_BITS-1:0]       cfg_index,
  input  wire logic [COEF_REG_BITS-1:0]      cfg_data,
  input  wire logic                          in_valid,
  input  wire logic                          in_ready,
  input  wire logic                          in_func,
  input  wire rgb_t                          in_pix,
  output logic                               item_valid,
  output logic [CW-1:0]                      item_col,
  output rgb_t                               item_pix,
  output item_flags_t                        item_flags,
  output logic                               clear,
  output logic signed [COEF_BITS-1:0]        taps [WIN_TAPS]
);

  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int HW = $clog2(MAX_HEIGHT + 1);
  localparam int RW = $clog2(MAX_HEIGHT + 2);

  logic [FRAME_W_BITS-1:0]  fw_r;
  logic [FRAME_H_BITS-1:0]  fh_r;
  logic [COEF_REG_BITS-1:0] coef_r [3];
  logic [CW-1:0]            col_r, col_nxt;
  logic [RW-1:0]            row_r, row_nxt;
  logic [WW-1:0]            eff_w;
  logic [HW-1:0]            eff_h;
  logic                     cfg_wr, accept, in_frame, live, col_zero;
  logic                     emit, row_end, last, col_wrap;

  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid && cfg_ready;
  assign clear     = cfg_wr && (cfg_index == CFG_FRAME_WIDTH || cfg_index == CFG_FRAME_HEIGHT);

  always_comb begin
    if (32'(fw_r) < 32'(MIN_WIDTH)) begin
      eff_w = WW'(MIN_WIDTH);
    end else if (32'(fw_r) > 32'(MAX_WIDTH)) begin
      eff_w = WW'(MAX_WIDTH);
    end else begin
      eff_w = WW'(fw_r);
    end
    if (fh_r == '0) begin
      eff_h = HW'(1);
    end else if (32'(fh_r) > 32'(MAX_HEIGHT)) begin
      eff_h = HW'(MAX_HEIGHT);
    end else begin
      eff_h = HW'(fh_r);
    end
  end

  assign accept   = in_valid && in_ready;
  assign in_frame = 32'(row_r) < 32'(eff_h);
  // Pixels count only inside the frame, drain items only after it.
  assign live     = in_frame ? (in_func == FUNC_PIXEL) : (in_func == FUNC_DRAIN);
  assign col_zero = (col_r == '0);
  assign emit     = (32'(row_r) >= 32'd2) || ((32'(row_r) == 32'd1) && !col_zero);
  assign row_end  = 32'(row_r) == 32'(eff_h) + 32'd1;
  assign last     = emit && col_zero && row_end;
  assign col_wrap = 32'(col_r) + 32'd1 >= 32'(eff_w);

  always_comb begin
    col_nxt = col_r + CW'(1);
    row_nxt = row_r;
    if (last) begin
      col_nxt = '0;
      row_nxt = '0;
    end else if (col_wrap) begin
      col_nxt = '0;
      row_nxt = row_r + RW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fw_r   <= FRAME_W_BITS'(MIN_WIDTH);
      fh_r   <= FRAME_H_BITS'(1);
      coef_r <= '{default: '0};
      col_r  <= '0;
      row_r  <= '0;
    end else begin
      if (cfg_wr) begin
        unique case (cfg_index)
          CFG_FRAME_WIDTH:  fw_r      <= cfg_data[FRAME_W_BITS-1:0];
          CFG_FRAME_HEIGHT: fh_r      <= cfg_data[FRAME_H_BITS-1:0];
          CFG_COEF_TOP:     coef_r[0] <= cfg_data;
          CFG_COEF_MID:     coef_r[1] <= cfg_data;
          CFG_COEF_BOTTOM:  coef_r[2] <= cfg_data;
          default: ;
        endcase
      end
      if (clear) begin
        col_r <= '0;
        row_r <= '0;
      end else if (accept && live) begin
        col_r <= col_nxt;
        row_r <= row_nxt;
      end
    end
  end

  // At the start of a row the pending result uses the zero column on the right,
  // and its centre row is two rows up, so the top test moves by one.
  always_comb begin
    item_valid          = accept && live;
    item_col            = col_r;
    item_pix            = in_frame ? in_pix : '0;
    item_flags.emit     = emit;
    item_flags.left_ok  = col_zero || (32'(col_r) >= 32'd2);
    item_flags.top_ok   = col_zero ? (32'(row_r) >= 32'd3) : (32'(row_r) >= 32'd2);
    item_flags.right_ok = !col_zero;
    item_flags.last     = last;
  end

  for (genvar j = 0; j < 3; j++) begin : g_row
    for (genvar k = 0; k < 3; k++) begin : g_col
      assign taps[k*3 + j] = coef_r[j][COEF_SLOT_BITS*k +: COEF_BITS];
    end
  end

`ifndef NO_ASSERTIONS
  a_row_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(row_r) <= 32'(eff_h) + 32'd1)
    else $error("row counter ran past the drain row");

  a_frame_restart: assert property (@(posedge clk) disable iff (!rst_n)
    (item_valid && last) |=> (col_r == '0 && row_r == '0))
    else $error("counters did not restart after the final result");
`endif

endmodule

`default_nettype wire

[hw/rtl/rgbc_window.sv]
// ----------------------------------------------------------------------------
// rgbc_window
// Two line stores with read-modify-write and forwarding, plus the 3x3 window.
// ----------------------------------------------------------------------------
`default_nettype none

module rgbc_window
  import rgbc_pkg::*;
#(
  parameter int MAX_WIDTH = 2048,
  localparam int CW = $clog2(MAX_WIDTH)
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          clear,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire logic [CW-1:0] in_col,
  input  wire rgb_t          in_pix,
  input  wire item_flags_t   in_flags,
  output logic               op_valid,
  input  wire logic          op_ready,
  output rgb_t               op_pix [WIN_TAPS],
  output logic               op_last
);

  rgb_t        mem_a [MAX_WIDTH];  // row above the incoming one
  rgb_t        mem_b [MAX_WIDTH];  // two rows above
  rgb_t        rd_a_r, rd_b_r;
  logic        s1_v_r, fwd_v_r;
  logic [CW-1:0] s1_col_r;
  rgb_t        s1_pix_r, fwd_a_r, fwd_b_r;
  item_flags_t s1_flags_r;
  rgb_t        win_r [WIN_TAPS];   // [col*3 + row], col 0 oldest, row 0 top
  rgb_t        cur_a, cur_b;
  logic        s1_leave, load;

  assign s1_leave = s1_v_r && (op_ready || !s1_flags_r.emit);
  assign in_ready = !s1_v_r || s1_leave;
  assign load     = in_valid && in_ready;

  // The item leaving this stage writes back at the same edge the next one
  // reads; on a matching column the read returns old data, so forward.
  assign cur_a = fwd_v_r ? fwd_a_r : rd_a_r;
  assign cur_b = fwd_v_r ? fwd_b_r : rd_b_r;

  always_ff @(posedge clk) begin
    if (s1_leave) begin
      mem_a[s1_col_r] <= s1_pix_r;
      mem_b[s1_col_r] <= cur_a;
    end
    if (load) begin
      rd_a_r <= mem_a[in_col];
      rd_b_r <= mem_b[in_col];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      fwd_v_r <= 1'b0;
    end else begin
      if (in_ready) begin
        s1_v_r <= in_valid;
      end
      if (load) begin
        fwd_v_r <= s1_leave && (in_col == s1_col_r);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      s1_col_r   <= in_col;
      s1_pix_r   <= in_pix;
      s1_flags_r <= in_flags;
      fwd_a_r    <= s1_pix_r;
      fwd_b_r    <= cur_a;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r <= '{default: '0};
    end else if (clear) begin
      win_r <= '{default: '0};
    end else if (s1_leave) begin
      if (s1_flags_r.last) begin
        win_r <= '{default: '0};
      end else begin
        for (int i = 0; i < 6; i++) begin
          win_r[i] <= win_r[i+3];
        end
        win_r[6] <= cur_b;
        win_r[7] <= cur_a;
        win_r[8] <= s1_pix_r;
      end
    end
  end

  // Operands: left = window column 1, centre = column 2, right = incoming
  // column (or zero at the start of a row).
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      op_pix[i]   = s1_flags_r.left_ok ? win_r[3+i] : '0;
      op_pix[3+i] = win_r[6+i];
    end
    op_pix[6] = s1_flags_r.right_ok ? cur_b : '0;
    op_pix[7] = s1_flags_r.right_ok ? cur_a : '0;
    op_pix[8] = s1_flags_r.right_ok ? s1_pix_r : '0;
    if (!s1_flags_r.top_ok) begin
      op_pix[0] = '0;
      op_pix[3] = '0;
      op_pix[6] = '0;
    end
    op_valid = s1_v_r && s1_flags_r.emit;
    op_last  = s1_flags_r.last;
  end

`ifndef NO_ASSERTIONS
  a_clear_window: assert property (@(posedge clk) disable iff (!rst_n)
    clear |=> ({win_r[0], win_r[1], win_r[2], win_r[3], win_r[4], win_r[5],
                win_r[6], win_r[7], win_r[8]} == '0))
    else $error("window not cleared after a frame size write");
`endif

endmodule

`default_nettype wire

[hw/rtl/rgbc_mac.sv]
// ----------------------------------------------------------------------------
// rgbc_mac
// Multiply, row sums, final sum and clamp for the three channels.
// ----------------------------------------------------------------------------
`default_nettype none

module rgbc_mac
  import rgbc_pkg::*;
#(
  parameter int COEF_BITS = 16
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire rgb_t                        in_pix [WIN_TAPS],
  input  wire logic                        in_last,
  input  wire logic signed [COEF_BITS-1:0] taps [WIN_TAPS],
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output rgb_t                             out_pix,
  output logic                             out_last
);

  localparam int PROD_W = COEF_BITS + PIX_W + 1;
  localparam int ROW_W  = PROD_W + 2;
  localparam int SUM_W  = PROD_W + 4;

  logic signed [PROD_W-1:0] prod_nxt [3][WIN_TAPS];
  logic signed [PROD_W-1:0] prod_r   [3][WIN_TAPS];
  logic signed [ROW_W-1:0]  rs_nxt   [3][3];
  logic signed [ROW_W-1:0]  rs_r     [3][3];
  logic signed [SUM_W-1:0]  sum_nxt  [3];
  logic [PIX_W-1:0]         clamp_nxt [3];
  logic                     v2_r, v3_r, l2_r, l3_r;
  logic                     ready3, ready4;

  function automatic logic [PIX_W-1:0] chan(input rgb_t p, input int ch);
    logic [PIX_W-1:0] v;
    case (ch)
      0:       v = p.red;
      1:       v = p.green;
      default: v = p.blue;
    endcase
    return v;
  endfunction

  assign ready4   = !out_valid || out_ready;
  assign ready3   = !v3_r || ready4;
  assign in_ready = !v2_r || ready3;

  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      for (int i = 0; i < WIN_TAPS; i++) begin
        prod_nxt[ch][i] = PROD_W'(signed'({1'b0, chan(in_pix[i], ch)}))
                        * PROD_W'(taps[i]);
      end
      for (int j = 0; j < 3; j++) begin
        rs_nxt[ch][j] = ROW_W'(prod_r[ch][j]) + ROW_W'(prod_r[ch][3+j])
                      + ROW_W'(prod_r[ch][6+j]);
      end
      sum_nxt[ch] = SUM_W'(rs_r[ch][0]) + SUM_W'(rs_r[ch][1]) + SUM_W'(rs_r[ch][2]);
      if (sum_nxt[ch][SUM_W-1]) begin
        clamp_nxt[ch] = '0;
      end else if (sum_nxt[ch] > SUM_W'(CLAMP_MAX)) begin
        clamp_nxt[ch] = PIX_W'(CLAMP_MAX);
      end else begin
        clamp_nxt[ch] = sum_nxt[ch][PIX_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r      <= 1'b0;
      v3_r      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (in_ready) begin
        v2_r <= in_valid;
      end
      if (ready3) begin
        v3_r <= v2_r;
      end
      if (ready4) begin
        out_valid <= v3_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      prod_r <= prod_nxt;
      l2_r   <= in_last;
    end
    if (ready3 && v2_r) begin
      rs_r <= rs_nxt;
      l3_r <= l2_r;
    end
    if (ready4 && v3_r) begin
      out_pix.red   <= clamp_nxt[0];
      out_pix.green <= clamp_nxt[1];
      out_pix.blue  <= clamp_nxt[2];
      out_last      <= l3_r;
    end
  end

`ifndef NO_ASSERTIONS
  a_sum_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    (v3_r && ready4) |=> out_valid)
    else $error("summed item lost before the output register");
`endif

endmodule

`default_nettype wire

[hw/rtl/rgb_conv3x3_clamp.sv]
// ----------------------------------------------------------------------------
// rgb_conv3x3_clamp
// Streaming 3x3 RGB convolution with zero padding and 0..255 clamping.
// ----------------------------------------------------------------------------
// Takes one item per clock when the output side keeps up. Each item does one
// read-modify-write of the two line stores at its column, so one column access
// per cycle sets the rate; the result passes the window stage, product, row-sum
// and output registers. A result belongs to the pixel one row and one pixel
// before the item that releases it, so after a frame's pixels the source sends
// drain items (tuser = 1) until the result with tlast arrives: one row plus
// one item. Writing the frame width or height restarts the frame; write
// registers only while no item is in flight. No clearing pass after reset.
`default_nettype none

module rgb_conv3x3_clamp
  import rgbc_pkg::*;
#(
  parameter int MAX_WIDTH  = 2048,
  parameter int MAX_HEIGHT = 4096,
  parameter int COEF_BITS  = 16
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     cfg_valid,
  output logic                          cfg_ready,
  input  wire logic [CFG_IDX_BITS-1:0]  cfg_index,
  input  wire logic [COEF_REG_BITS-1:0] cfg_data,
  input  wire logic                     in_tvalid,
  output logic                          in_tready,
  input  wire logic [23:0]              in_tdata,   // pixel_red, pixel_green, pixel_blue
  input  wire logic [0:0]               in_tuser,   // func
  output logic                          out_tvalid,
  input  wire logic                     out_tready,
  output logic [23:0]                   out_tdata,  // out_red, out_green, out_blue
  output logic                          out_tlast   // last_of_frame
);

  localparam int CW = $clog2(MAX_WIDTH);

  rgb_t                        in_pix, item_pix, out_pix;
  logic                        item_valid, clear, op_valid, op_ready, op_last;
  logic [CW-1:0]               item_col;
  item_flags_t                 item_flags;
  logic signed [COEF_BITS-1:0] taps [WIN_TAPS];
  rgb_t                        op_pix [WIN_TAPS];

  assign in_pix.red   = in_tdata[7:0];
  assign in_pix.green = in_tdata[15:8];
  assign in_pix.blue  = in_tdata[23:16];
  assign out_tdata    = {out_pix.blue, out_pix.green, out_pix.red};

  rgbc_ctrl #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .COEF_BITS  (COEF_BITS)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .in_func    (in_tuser[0]),
    .in_pix     (in_pix),
    .item_valid (item_valid),
    .item_col   (item_col),
    .item_pix   (item_pix),
    .item_flags (item_flags),
    .clear      (clear),
    .taps       (taps)
  );

  rgbc_window #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_window (
    .clk      (clk),
    .rst_n    (rst_n),
    .clear    (clear),
    .in_valid (item_valid),
    .in_ready (in_tready),
    .in_col   (item_col),
    .in_pix   (item_pix),
    .in_flags (item_flags),
    .op_valid (op_valid),
    .op_ready (op_ready),
    .op_pix   (op_pix),
    .op_last  (op_last)
  );

  rgbc_mac #(
    .COEF_BITS (COEF_BITS)
  ) u_mac (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (op_valid),
    .in_ready  (op_ready),
    .in_pix    (op_pix),
    .in_last   (op_last),
    .taps      (taps),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_pix   (out_pix),
    .out_last  (out_tlast)
  );

endmodule

`default_nettype wire

[sim/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Stream-level test of the 3x3 RGB convolution with zero padding and clamping.
// ----------------------------------------------------------------------------
// A feed queue filled by the stimulus process drives the pixel stream. The
// driver offers items with random gaps, and a monitor takes results with
// random stalls and one long hold-off. Every accepted item runs through a
// local model of the line stores and the window. The model's results are
// queued and compared field by field with what the block puts out. Register
// writes happen only while nothing is in flight. They cover clamped frame
// sizes, odd widths, extreme and small taps, partial frames cut off by a
// restart, drains before the last pixel and pixels during the drain.
`default_nettype none

module tb;
  import rgbc_pkg::*;

  localparam int MAX_COLS       = 2048;
  localparam int MAX_ROWS       = 4096;
  localparam int IDLE_PCT       = 37;
  localparam int HOLD_CYCLES    = 600;
  localparam int SETTLE_CYCLES  = 16;
  localparam int RANDOM_ITEMS   = 1130;
  localparam int FINAL_WAIT     = 20000;
  localparam int TIMEOUT_CYCLES = 200000;

  // Index with no register behind it; a write there must change nothing.
  localparam logic [CFG_IDX_BITS-1:0] CFG_SPARE_IDX = 3'd7;

  typedef struct packed {
    logic func;
    rgb_t px;
  } feed_item_t;

  typedef struct packed {
    rgb_t px;
    logic last;
  } filtered_t;

  logic                     clk = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     cfg_valid = 1'b0;
  logic                     cfg_ready;
  logic [CFG_IDX_BITS-1:0]  cfg_index = '0;
  logic [COEF_REG_BITS-1:0] cfg_data = '0;
  logic                     in_tvalid = 1'b0;
  logic                     in_tready;
  logic [23:0]              in_tdata = '0;   // pixel_red, pixel_green, pixel_blue
  logic [0:0]               in_tuser = '0;   // func
  logic                     out_tvalid;
  logic                     out_tready = 1'b0;
  logic [23:0]              out_tdata;       // out_red, out_green, out_blue
  logic                     out_tlast;       // last_of_frame

  rgb_conv3x3_clamp DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  feed_item_t feed[$];
  filtered_t  filtered_q[$];
  int         mismatches = 0;
  int         items_taken = 0;
  bit         in_steady = 1'b0;
  bit         out_steady = 1'b0;
  int         hold_req = 0;
  int         hold_done = 0;
  int         hold_left = 0;

  // Model state: line stores, window [column][row] with column 0 oldest and
  // row 0 on top, position counters and registers.
  rgb_t                     line_a [MAX_COLS];
  rgb_t                     line_b [MAX_COLS];
  rgb_t [2:0][2:0]          win_q;
  int                       col_cnt;
  int                       row_cnt;
  int                       emit_cnt;
  logic [FRAME_W_BITS-1:0]  width_reg;
  logic [FRAME_H_BITS-1:0]  height_reg;
  logic [COEF_REG_BITS-1:0] coef_reg [3];

  task automatic flag_error(string msg);
    mismatches++;
    $display("[%0t] mismatch: %s", $time, msg);
  endtask

  function automatic void restart_frame();
    col_cnt  = 0;
    row_cnt  = 0;
    emit_cnt = 0;
    win_q    = '0;
  endfunction

  function automatic void apply_reg(logic [CFG_IDX_BITS-1:0] idx,
                                    logic [COEF_REG_BITS-1:0] val);
    case (idx)
      CFG_FRAME_WIDTH: begin
        width_reg = val[FRAME_W_BITS-1:0];
        restart_frame();
      end
      CFG_FRAME_HEIGHT: begin
        height_reg = val[FRAME_H_BITS-1:0];
        restart_frame();
      end
      CFG_COEF_TOP:    coef_reg[0] = val;
      CFG_COEF_MID:    coef_reg[1] = val;
      CFG_COEF_BOTTOM: coef_reg[2] = val;
      default: ;
    endcase
  endfunction

  function automatic int eff_width();
    if (width_reg < MIN_WIDTH) return MIN_WIDTH;
    if (width_reg > MAX_COLS) return MAX_COLS;
    return int'(width_reg);
  endfunction

  function automatic int eff_height();
    if (height_reg < 1) return 1;
    if (height_reg > MAX_ROWS) return MAX_ROWS;
    return int'(height_reg);
  endfunction

  function automatic int coef_tap(int row, int slot);
    logic signed [COEF_SLOT_BITS-1:0] t16;
    t16 = coef_reg[row][COEF_SLOT_BITS*slot +: COEF_SLOT_BITS];
    return t16;
  endfunction

  function automatic logic [PIX_W-1:0] clip8(int s);
    if (s < 0) return '0;
    if (s > CLAMP_MAX) return PIX_W'(CLAMP_MAX);
    return s[PIX_W-1:0];
  endfunction

  function automatic rgb_t conv_window(rgb_t [2:0][2:0] v, bit top_ok, bit left_ok);
    int   acc_r, acc_g, acc_b, t;
    rgb_t res;
    acc_r = 0;
    acc_g = 0;
    acc_b = 0;
    for (int j = 0; j < 3; j++) begin
      if (j == 0 && !top_ok) continue;
      for (int k = 0; k < 3; k++) begin
        if (k == 0 && !left_ok) continue;
        t = coef_tap(j, k);
        acc_r += int'(v[k][j].red) * t;
        acc_g += int'(v[k][j].green) * t;
        acc_b += int'(v[k][j].blue) * t;
      end
    end
    res.red   = clip8(acc_r);
    res.green = clip8(acc_g);
    res.blue  = clip8(acc_b);
    return res;
  endfunction

  // Advances the model by one accepted item and queues the result it releases.
  function automatic void step_conv(logic func, rgb_t px);
    int              w, h, c, r;
    bit              produce, made;
    rgb_t [2:0][2:0] view;
    rgb_t            res;
    filtered_t       item;
    w    = eff_width();
    h    = eff_height();
    c    = col_cnt;
    r    = row_cnt;
    made = 1'b0;
    res  = '0;
    // Drains before the last pixel and pixels after it are dropped.
    if (r < h) begin
      if (func == FUNC_DRAIN) return;
    end else begin
      if (func == FUNC_PIXEL) return;
      px = '0;
    end
    produce = (r * w + c) >= (w + 1);
    // The first column of a row finishes the last pixel of the row two above.
    if (c == 0 && produce) begin
      view[0] = win_q[1];
      view[1] = win_q[2];
      view[2] = '0;
      res  = conv_window(view, r >= 3, 1'b1);
      made = 1'b1;
    end
    win_q[0]    = win_q[1];
    win_q[1]    = win_q[2];
    win_q[2][0] = line_b[c];
    win_q[2][1] = line_a[c];
    win_q[2][2] = px;
    line_b[c]   = line_a[c];
    line_a[c]   = px;
    if (c >= 1 && produce) begin
      res  = conv_window(win_q, r >= 2, c >= 2);
      made = 1'b1;
    end
    c++;
    if (c >= w) begin
      c = 0;
      r++;
    end
    col_cnt = c;
    row_cnt = r;
    if (made) begin
      item.px   = res;
      item.last = (emit_cnt + 1 == w * h);
      filtered_q.push_back(item);
      emit_cnt++;
      if (item.last) restart_frame();
    end
  endfunction

  // Pixel stream driver.
  always @(posedge clk) begin : driver
    feed_item_t nxt;
    rgb_t       got;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        got = {in_tdata[7:0], in_tdata[15:8], in_tdata[23:16]};
        step_conv(in_tuser[0], got);
        items_taken++;
      end
      if (!in_tvalid || in_tready) begin
        if (feed.size() != 0 && (in_steady || $urandom_range(0, 99) >= IDLE_PCT)) begin
          nxt = feed.pop_front();
          in_tvalid <= 1'b1;
          in_tdata  <= {nxt.px.blue, nxt.px.green, nxt.px.red};
          in_tuser  <= nxt.func;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Result monitor with random stalls and a requested long hold-off.
  always @(posedge clk) begin : monitor
    filtered_t want;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (filtered_q.size() == 0) begin
          flag_error($sformatf("result %h with none pending", out_tdata));
        end else begin
          want = filtered_q.pop_front();
          if (out_tdata[7:0] !== want.px.red)
            flag_error($sformatf("red %h, model %h", out_tdata[7:0], want.px.red));
          if (out_tdata[15:8] !== want.px.green)
            flag_error($sformatf("green %h, model %h", out_tdata[15:8], want.px.green));
          if (out_tdata[23:16] !== want.px.blue)
            flag_error($sformatf("blue %h, model %h", out_tdata[23:16], want.px.blue));
          if (out_tlast !== want.last)
            flag_error($sformatf("tlast %b, model %b", out_tlast, want.last));
        end
      end
      if (hold_done != hold_req) begin
        hold_done = hold_req;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= out_steady || ($urandom_range(0, 99) >= IDLE_PCT);
      end
    end
  end

  task automatic write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [COEF_REG_BITS-1:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    apply_reg(idx, val);
  endtask

  task automatic set_frame(int w_raw, int h_raw, logic [47:0] top, logic [47:0] mid,
                           logic [47:0] bot);
    write_reg(CFG_FRAME_WIDTH, COEF_REG_BITS'(w_raw));
    write_reg(CFG_FRAME_HEIGHT, COEF_REG_BITS'(h_raw));
    write_reg(CFG_COEF_TOP, top);
    write_reg(CFG_COEF_MID, mid);
    write_reg(CFG_COEF_BOTTOM, bot);
  endtask

  // Waits until every item is taken and every result is in, then lets the
  // pipeline run dry before registers may change.
  task automatic settle();
    @(negedge clk);
    while (feed.size() != 0 || in_tvalid) @(negedge clk);
    while (filtered_q.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  function automatic void push_item(logic func, rgb_t px);
    feed_item_t it;
    it.func = func;
    it.px   = px;
    feed.push_back(it);
  endfunction

  function automatic rgb_t rand_pixel(int style);
    rgb_t p;
    case (style)
      1: p = {($urandom_range(0, 1) ? 8'hFF : 8'h00), ($urandom_range(0, 1) ? 8'hFF : 8'h00),
              ($urandom_range(0, 1) ? 8'hFF : 8'h00)};
      2: p = {8'($urandom_range(0, 15)), 8'($urandom_range(0, 15)), 8'($urandom_range(0, 15))};
      default: p = 24'($urandom);
    endcase
    return p;
  endfunction

  function automatic logic [47:0] rand_coef(int style);
    logic [47:0] v;
    logic [15:0] t;
    int          s;
    v = '0;
    for (int k = 0; k < 3; k++) begin
      case (style)
        0: t = 16'($urandom);
        2: begin
          s = $urandom_range(0, 3);
          t = (s == 0) ? 16'h8000 : (s == 1) ? 16'h7FFF : (s == 2) ? 16'hFFFF : 16'h0001;
        end
        default: begin
          s = int'($urandom_range(0, 6)) - 3;
          t = s[15:0];
        end
      endcase
      v[16*k +: 16] = t;
    end
    return v;
  endfunction

  // Queues the first cut pixels of a w x h frame; a full frame also gets its
  // w+1 drains. Noise adds drains before the last pixel, pixels during the
  // drain and one drain after the frame has ended, all of them ignored.
  task automatic queue_frame(int w, int h, bit noisy, int pstyle, int cut);
    for (int i = 0; i < cut; i++) begin
      if (noisy && $urandom_range(0, 19) == 0) push_item(FUNC_DRAIN, rand_pixel(0));
      push_item(FUNC_PIXEL, rand_pixel(pstyle));
    end
    if (cut < w * h) return;
    for (int i = 0; i <= w; i++) begin
      if (noisy && $urandom_range(0, 15) == 0) push_item(FUNC_PIXEL, rand_pixel(0));
      push_item(FUNC_DRAIN, rand_pixel(0));
    end
    if (noisy) push_item(FUNC_DRAIN, rand_pixel(0));
  endtask

  initial begin : timeout
    repeat (TIMEOUT_CYCLES) @(posedge clk);
    $display("TB_ERROR");
    $finish;
  end

  initial begin : stimulus
    int   sel, w_raw, h_raw, w_eff, h_eff, cut, base;
    int   random_items;
    rgb_t p;
    for (int i = 0; i < MAX_COLS; i++) begin
      line_a[i] = '0;
      line_b[i] = '0;
    end
    width_reg  = FRAME_W_BITS'(MIN_WIDTH);
    height_reg = FRAME_H_BITS'(1);
    coef_reg[0] = '0;
    coef_reg[1] = '0;
    coef_reg[2] = '0;
    restart_frame();
    random_items = 0;

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(negedge clk);

    // Reset frame size with a pass-through kernel: a drain before any pixel,
    // pixels at the channel extremes, and pixels mixed into the drain.
    write_reg(CFG_COEF_MID, {16'h0000, 16'h0001, 16'h0000});
    push_item(FUNC_DRAIN, '0);
    for (int i = 0; i < 32; i++) begin
      p.red   = (i % 2) ? 8'hFF : 8'h00;
      p.green = 8'(i * 8);
      p.blue  = 8'(255 - i * 8);
      push_item(FUNC_PIXEL, p);
    end
    for (int i = 0; i <= 32; i++) begin
      if (i == 3 || i == 32) push_item(FUNC_PIXEL, 24'hFFFFFF);
      push_item(FUNC_DRAIN, '0);
    end
    push_item(FUNC_DRAIN, 24'hFFFFFF);
    settle();

    // Width zero is taken as the minimum, extreme taps on every row.
    set_frame(0, 3, {16'h0001, 16'h8000, 16'h7FFF}, {16'hFFFF, 16'h7FFF, 16'h8000},
              {16'h7FFF, 16'h8000, 16'h0000});
    queue_frame(32, 3, 1'b0, 1, 96);
    settle();

    // Width that is not a multiple of 32, receiver never stalling.
    out_steady = 1'b1;
    set_frame(33, 2, rand_coef(1), rand_coef(1), rand_coef(1));
    queue_frame(33, 2, 1'b1, 2, 66);
    settle();
    out_steady = 1'b0;

    // Oversized height, cut off after two rows and five pixels by a restart.
    set_frame(32, 8191, rand_coef(1), rand_coef(1), rand_coef(1));
    queue_frame(32, MAX_ROWS, 1'b1, 0, 69);
    settle();
    write_reg(CFG_SPARE_IDX, {48{1'b1}});

    // Oversized width clamps to the widest row, so a short run of pixels
    // releases no result at all.
    set_frame(4095, 1, rand_coef(1), rand_coef(1), rand_coef(0));
    queue_frame(MAX_COLS, 1, 1'b0, 0, 64);
    settle();

    // The receiver holds off while the sender keeps offering, so the block
    // has to stall its input.
    in_steady = 1'b1;
    set_frame(32, 4, rand_coef(1), rand_coef(1), rand_coef(0));
    base = items_taken;
    queue_frame(32, 4, 1'b0, 0, 128);
    while (items_taken < base + 64) @(negedge clk);
    hold_req++;
    settle();
    in_steady = 1'b0;

    while (random_items < RANDOM_ITEMS) begin
      sel   = $urandom_range(0, 9);
      w_raw = (sel < 6) ? 32 : (sel < 8) ? 64 :
              (sel == 8) ? $urandom_range(33, 63) : $urandom_range(0, 31);
      h_raw = $urandom_range(0, 4);
      w_eff = (w_raw < MIN_WIDTH) ? MIN_WIDTH : w_raw;
      h_eff = (h_raw == 0) ? 1 : h_raw;
      set_frame(w_raw, h_raw, rand_coef($urandom_range(0, 3)), rand_coef($urandom_range(0, 3)),
                rand_coef($urandom_range(0, 3)));
      if ($urandom_range(0, 7) == 0) begin
        cut = $urandom_range(1, w_eff * h_eff);
        queue_frame(w_eff, h_eff, 1'b1, 0, cut);
        random_items += cut;
      end else begin
        queue_frame(w_eff, h_eff, $urandom_range(0, 2) == 0, $urandom_range(0, 2),
                    w_eff * h_eff);
        random_items += w_eff * h_eff + w_eff + 1;
      end
      settle();
    end

    while (feed.size() != 0 || in_tvalid) @(negedge clk);
    for (int i = 0; i < FINAL_WAIT && filtered_q.size() != 0; i++) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (filtered_q.size() != 0)
      flag_error($sformatf("%0d results never arrived", filtered_q.size()));
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire
